// ===== design/assert_macros.svh =====
// Assertion macros used by the top level of the warp accumulator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property that must hold at every clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_IMPL(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ===== design/ewa_pkg.sv =====
// Shared types and constants of the event motion warp accumulator.
package ewa_pkg;

    // Default store geometry and counter width.
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;
    localparam int COUNT_BITS_DEF = 16;

    // Command codes of an input beat.
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_EVENT = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_REF_TIME = 2'd0;
    localparam logic [1:0] CFG_WIDTH    = 2'd1;
    localparam logic [1:0] CFG_HEIGHT   = 2'd2;

    // Configuration reset values.
    localparam logic [31:0] REF_TIME_RESET = 32'd0;
    localparam logic [8:0]  WIDTH_RESET    = 9'd240;
    localparam logic [8:0]  HEIGHT_RESET   = 9'd180;

    // Offset rounding: round(|p| / 256000), done as (|p| + 128000) >> 8, then / 1000.
    localparam int ROUND_HALF = 128000;
    localparam int PRE_SHIFT  = 8;
    // Quotients at or above 2^17 saturate and land outside the image anyway.
    localparam int QUOT_CLAMP = 131072000;
    localparam int V_W        = 27;
    localparam int Q_W        = 18;
    // Reciprocal of 1000, exact for every dividend below 2^27.
    localparam int RECIP_SHIFT = 37;
    localparam int RECIP_W     = 28;
    localparam logic [RECIP_W-1:0] RECIP_K =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd999) / 64'd1000);

    // Result of the warp unit.
    typedef struct packed {
        logic signed [15:0] warped_x;
        logic signed [15:0] warped_y;
        logic               in_bounds;
    } t_warp_res;

endpackage

// ===== design/event_motion_warp_accumulate.sv =====
// Top level of the event motion warp accumulator: sequencer, registers and memories.
//
// Input channel (i_in_valid / o_in_ready) takes one command beat: a flow write, an
// event, or a count read-and-clear. Output channel (o_out_valid / i_out_ready) gives
// exactly one result beat per command. Configuration is written through i_cfg_we,
// i_cfg_index and i_cfg_wdata, one register per cycle; the user must write it only
// while the block is idle, as the block does not enforce this. Per command, output free:
//   flow write, unused code, or event with source outside the image: result formed in
//   the accepting cycle; count read: count memory read, then clear write;
//   event: the flow memory read, the four-stage warp unit and the count
//   read-modify-write run one after another; the count step is skipped if the warped
//   point leaves the image.
// A result sits in the output register; the next beat is accepted while it waits.
// If a second result is ready before the first is taken, the sequencer holds it and
// stops accepting until the output register frees up.
// After reset the count memory is cleared one entry a cycle, all MAX_WIDTH*MAX_HEIGHT
// entries (65536 by default), during which o_in_ready stays low. The flow memory is
// not cleared; an entry must be written before an event reads it.
`include "assert_macros.svh"

module event_motion_warp_accumulate #(
    parameter int MAX_WIDTH  = ewa_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = ewa_pkg::MAX_HEIGHT_DEF,
    parameter int COUNT_BITS = ewa_pkg::COUNT_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_command,
    input  logic [7:0]         i_pixel_x,
    input  logic [7:0]         i_pixel_y,
    input  logic [31:0]        i_event_time,
    input  logic signed [15:0] i_flow_x_in,
    input  logic signed [15:0] i_flow_y_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [15:0]        o_count_value,
    output logic signed [15:0] o_warped_x,
    output logic signed [15:0] o_warped_y,
    output logic               o_in_bounds
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_FLOW  = 6'b000100,
        S_WARP  = 6'b001000,
        S_COUNT = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_clr_addr, n_clr_addr;
    logic [ADDR_W-1:0]   r_cnt_addr, n_cnt_addr;
    logic [31:0]         r_cfg_ref;
    logic [8:0]          r_cfg_width, r_cfg_height;
    logic                r_is_read;
    logic [7:0]          r_px, r_py;
    logic [31:0]         r_time;

    logic                r_out_valid;
    logic [15:0]         r_out_count;
    logic signed [15:0]  r_out_wx, r_out_wy;
    logic                r_out_inb;
    logic [15:0]         r_pend_count;
    logic signed [15:0]  r_pend_wx, r_pend_wy;
    logic                r_pend_inb;

    logic                accept, out_free;
    logic                src_store, src_img;
    logic [ADDR_W-1:0]   src_addr;
    logic                flow_en, flow_we;
    logic [31:0]         flow_rdata;
    logic                cnt_en, cnt_we;
    logic [ADDR_W-1:0]   cnt_addr;
    logic [COUNT_BITS-1:0] cnt_wdata, cnt_rdata;
    logic                warp_start, warp_valid;
    ewa_pkg::t_warp_res  warp_res;
    logic [ADDR_W-1:0]   warp_dst;
    logic                res_valid;
    logic [15:0]         res_count;
    logic signed [15:0]  res_wx, res_wy;
    logic                res_inb;
    logic                out_load;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    // Source pixel checks against the store and against the image in use.
    assign src_store = ({24'd0, i_pixel_x} < 32'(MAX_WIDTH))
                       && ({24'd0, i_pixel_y} < 32'(MAX_HEIGHT));
    assign src_img   = src_store && ({1'b0, i_pixel_x} < r_cfg_width)
                       && ({1'b0, i_pixel_y} < r_cfg_height);
    assign src_addr  = ADDR_W'(32'(i_pixel_y) * 32'(MAX_WIDTH) + 32'(i_pixel_x));

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_ref    <= ewa_pkg::REF_TIME_RESET;
            r_cfg_width  <= ewa_pkg::WIDTH_RESET;
            r_cfg_height <= ewa_pkg::HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ewa_pkg::CFG_REF_TIME: r_cfg_ref    <= i_cfg_wdata;
                ewa_pkg::CFG_WIDTH:    r_cfg_width  <= i_cfg_wdata[8:0];
                ewa_pkg::CFG_HEIGHT:   r_cfg_height <= i_cfg_wdata[8:0];
                default: ;
            endcase
        end
    end

    // Sequencer and memory port control.
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_cnt_addr = r_cnt_addr;
        flow_en    = 1'b0;
        flow_we    = 1'b0;
        cnt_en     = 1'b0;
        cnt_we     = 1'b0;
        cnt_addr   = r_cnt_addr;
        cnt_wdata  = '0;
        warp_start = 1'b0;
        res_valid  = 1'b0;
        res_count  = 16'd0;
        res_wx     = 16'sd0;
        res_wy     = 16'sd0;
        res_inb    = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                cnt_en   = 1'b1;
                cnt_we   = 1'b1;
                cnt_addr = r_clr_addr;
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + ADDR_W'(1);
                end
            end
            S_IDLE: begin
                if (accept) begin
                    unique case (i_command)
                        ewa_pkg::CMD_WRITE: begin
                            flow_en   = src_store;
                            flow_we   = 1'b1;
                            res_valid = 1'b1;
                        end
                        ewa_pkg::CMD_EVENT: begin
                            if (src_img) begin
                                flow_en = 1'b1;
                                n_state = S_FLOW;
                            end else begin
                                res_valid = 1'b1;
                            end
                        end
                        ewa_pkg::CMD_READ: begin
                            if (src_store) begin
                                cnt_en     = 1'b1;
                                cnt_addr   = src_addr;
                                n_cnt_addr = src_addr;
                                n_state    = S_COUNT;
                            end else begin
                                res_valid = 1'b1;
                            end
                        end
                        default: res_valid = 1'b1;
                    endcase
                end
            end
            S_FLOW: begin
                warp_start = 1'b1;
                n_state    = S_WARP;
            end
            S_WARP: begin
                if (warp_valid) begin
                    if (warp_res.in_bounds) begin
                        cnt_en     = 1'b1;
                        cnt_addr   = warp_dst;
                        n_cnt_addr = warp_dst;
                        n_state    = S_COUNT;
                    end else begin
                        res_valid = 1'b1;
                        res_wx    = warp_res.warped_x;
                        res_wy    = warp_res.warped_y;
                    end
                end
            end
            S_COUNT: begin
                cnt_en    = 1'b1;
                cnt_we    = 1'b1;
                res_valid = 1'b1;
                if (r_is_read) begin
                    cnt_wdata = '0;
                    res_count = 16'(cnt_rdata);
                end else begin
                    cnt_wdata = (cnt_rdata == '1) ? cnt_rdata
                                                  : cnt_rdata + COUNT_BITS'(1);
                    res_wx    = warp_res.warped_x;
                    res_wy    = warp_res.warped_y;
                    res_inb   = 1'b1;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        // A finished result goes to the output register, or waits if it is full.
        if (res_valid) begin
            n_state = out_free ? S_IDLE : S_EMIT;
        end
    end

    assign out_load = out_free && (res_valid || (r_state == S_EMIT));

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item, result and holding registers.
    always_ff @(posedge i_clk) begin
        r_cnt_addr <= n_cnt_addr;
        if (accept) begin
            r_is_read <= (i_command == ewa_pkg::CMD_READ);
            r_px      <= i_pixel_x;
            r_py      <= i_pixel_y;
            r_time    <= i_event_time;
        end
        if (res_valid && !out_free) begin
            r_pend_count <= res_count;
            r_pend_wx    <= res_wx;
            r_pend_wy    <= res_wy;
            r_pend_inb   <= res_inb;
        end
        if (out_load) begin
            if (r_state == S_EMIT) begin
                r_out_count <= r_pend_count;
                r_out_wx    <= r_pend_wx;
                r_out_wy    <= r_pend_wy;
                r_out_inb   <= r_pend_inb;
            end else begin
                r_out_count <= res_count;
                r_out_wx    <= res_wx;
                r_out_wy    <= res_wy;
                r_out_inb   <= res_inb;
            end
        end
    end

    // Flow table memory, low half horizontal and high half vertical flow.
    ewa_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_flow_ram (
        .i_clk   (i_clk),
        .i_en    (flow_en),
        .i_we    (flow_we),
        .i_addr  (src_addr),
        .i_wdata ({i_flow_y_in, i_flow_x_in}),
        .o_rdata (flow_rdata)
    );

    // Event count memory.
    ewa_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (DEPTH)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_en    (cnt_en),
        .i_we    (cnt_we),
        .i_addr  (cnt_addr),
        .i_wdata (cnt_wdata),
        .o_rdata (cnt_rdata)
    );

    // Warp arithmetic.
    ewa_warp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_warp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (warp_start),
        .i_flow       (flow_rdata),
        .i_ref_time   (r_cfg_ref),
        .i_event_time (r_time),
        .i_pixel_x    (r_px),
        .i_pixel_y    (r_py),
        .i_width      (r_cfg_width),
        .i_height     (r_cfg_height),
        .o_valid      (warp_valid),
        .o_res        (warp_res),
        .o_dst_addr   (warp_dst)
    );

    assign o_out_valid   = r_out_valid;
    assign o_count_value = r_out_count;
    assign o_warped_x    = r_out_wx;
    assign o_warped_y    = r_out_wy;
    assign o_in_bounds   = r_out_inb;

    // The warp unit reports only while the sequencer waits for it.
    `ASSERT_NEVER(a_warp_in_wait, i_clk, i_rst_n, warp_valid && (r_state != S_WARP))
    // A held result exists only while the output register is still occupied.
    `ASSERT_IMPL(a_emit_busy, i_clk, i_rst_n, (r_state == S_EMIT) |-> r_out_valid)
    // The count write-back goes to the entry that was just read.
    `ASSERT_IMPL(a_rmw_addr, i_clk, i_rst_n,
        (r_state == S_COUNT) |-> (cnt_en && cnt_we && (cnt_addr == $past(cnt_addr))))
    // An event inside the image always starts a flow lookup.
    `ASSERT_IMPL(a_event_flow, i_clk, i_rst_n,
        (accept && (i_command == ewa_pkg::CMD_EVENT) && src_img) |=> (r_state == S_FLOW))

endmodule

// ===== design/ewa_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
module ewa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write, or read into the output register.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/ewa_warp.sv =====
// Four-stage warp unit: time scaling, rounding, division by 1000, and bounds test.
module ewa_warp #(
    parameter int MAX_WIDTH  = ewa_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = ewa_pkg::MAX_HEIGHT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [31:0]          i_flow,
    input  logic [31:0]          i_ref_time,
    input  logic [31:0]          i_event_time,
    input  logic [7:0]           i_pixel_x,
    input  logic [7:0]           i_pixel_y,
    input  logic [8:0]           i_width,
    input  logic [8:0]           i_height,
    output logic                 o_valid,
    output ewa_pkg::t_warp_res   o_res,
    output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] o_dst_addr
);

    localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int V_W    = ewa_pkg::V_W;
    localparam int Q_W    = ewa_pkg::Q_W;

    // Magnitude rounded at the binary step and clamped where saturation is certain.
    function automatic logic [V_W-1:0] scaled_mag(input logic signed [48:0] p);
        logic [47:0] mag;
        logic [48:0] m;
        logic [40:0] v;
        mag = p[48] ? 48'(-p) : 48'(p);
        m   = {1'b0, mag} + 49'(ewa_pkg::ROUND_HALF);
        v   = m[48:ewa_pkg::PRE_SHIFT];
        return (v >= 41'(ewa_pkg::QUOT_CLAMP)) ? V_W'(ewa_pkg::QUOT_CLAMP) : v[V_W-1:0];
    endfunction

    // Pixel plus signed offset.
    function automatic logic signed [19:0] warp_pos(input logic [7:0] pix,
                                                    input logic [Q_W-1:0] q,
                                                    input logic neg);
        logic signed [19:0] off;
        off = signed'(20'(q));
        if (neg) begin
            off = -off;
        end
        return signed'(20'(pix)) + off;
    endfunction

    // Clamp to the signed 16-bit range.
    function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
        logic signed [15:0] s;
        if (v > 20'sd32767) begin
            s = 16'sh7FFF;
        end else if (v < -20'sd32768) begin
            s = 16'sh8000;
        end else begin
            s = v[15:0];
        end
        return s;
    endfunction

    logic                 r_v1, r_v2, r_v3, r_v4;
    logic signed [48:0]   r_prod_x, r_prod_y;
    logic [V_W-1:0]       r_mag_x, r_mag_y;
    logic                 r_neg2_x, r_neg2_y;
    logic [Q_W-1:0]       r_q_x, r_q_y;
    logic                 r_neg3_x, r_neg3_y;
    ewa_pkg::t_warp_res   r_res;
    logic [ADDR_W-1:0]    r_dst;

    logic signed [32:0]   dt;
    logic signed [48:0]   prod_x, prod_y;
    logic [V_W+ewa_pkg::RECIP_W-1:0] recip_x, recip_y;
    logic signed [19:0]   pos_x, pos_y;
    logic                 in_x, in_y;

    // Stage one: time difference times flow, one multiplier per axis.
    assign dt     = signed'({1'b0, i_ref_time}) - signed'({1'b0, i_event_time});
    assign prod_x = dt * signed'(i_flow[15:0]);
    assign prod_y = dt * signed'(i_flow[31:16]);

    // Stage three: division by 1000 through the reciprocal.
    assign recip_x = r_mag_x * ewa_pkg::RECIP_K;
    assign recip_y = r_mag_y * ewa_pkg::RECIP_K;

    // Stage four: warped position and bounds against the image in use.
    assign pos_x = warp_pos(i_pixel_x, r_q_x, r_neg3_x);
    assign pos_y = warp_pos(i_pixel_y, r_q_y, r_neg3_y);
    assign in_x  = !pos_x[19] && (pos_x[18:0] < 19'(i_width)) && (pos_x[18:0] < 19'(MAX_WIDTH));
    assign in_y  = !pos_y[19] && (pos_y[18:0] < 19'(i_height))
                   && (pos_y[18:0] < 19'(MAX_HEIGHT));

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // Stage data registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod_x <= prod_x;
            r_prod_y <= prod_y;
        end
        if (r_v1) begin
            r_mag_x  <= scaled_mag(r_prod_x);
            r_mag_y  <= scaled_mag(r_prod_y);
            r_neg2_x <= r_prod_x[48];
            r_neg2_y <= r_prod_y[48];
        end
        if (r_v2) begin
            r_q_x    <= recip_x[ewa_pkg::RECIP_SHIFT +: Q_W];
            r_q_y    <= recip_y[ewa_pkg::RECIP_SHIFT +: Q_W];
            r_neg3_x <= r_neg2_x;
            r_neg3_y <= r_neg2_y;
        end
        if (r_v3) begin
            r_res.warped_x  <= sat16(pos_x);
            r_res.warped_y  <= sat16(pos_y);
            r_res.in_bounds <= in_x && in_y;
            r_dst <= ADDR_W'(32'(pos_y[12:0]) * 32'(MAX_WIDTH) + 32'(pos_x[12:0]));
        end
    end

    assign o_valid    = r_v4;
    assign o_res      = r_res;
    assign o_dst_addr = r_dst;

endmodule
